// File: hw/rtl/poi_pkg.sv
package poi_pkg;

    // Field widths
    localparam int POS_W  = 32;
    localparam int HEAD_W = 16;
    localparam int DT_W   = 20;
    localparam int THR_W  = 16;
    localparam int VEL_W  = 32;
    localparam int DIFF_W = POS_W + 1;

    // Trig unit
    localparam int ANGLE_BITS      = 16;
    localparam int TRIG_ITERATIONS = 16;
    localparam int ATAN_ENTRIES    = 24;
    localparam int CORDIC_ITERS    = (TRIG_ITERATIONS < ATAN_ENTRIES) ?
                                     TRIG_ITERATIONS : ATAN_ENTRIES;
    localparam int CORDIC_IDX_W    = $clog2(CORDIC_ITERS);
    localparam int ATAN_IDX_W      = $clog2(ATAN_ENTRIES);
    localparam int ANG_W           = 32;
    localparam int CORDIC_W        = 34;
    localparam int TRIG_W          = 32;

    localparam logic [ANG_W-1:0] ANGLE_MASK =
        ~((ANG_W'(1) << (ANG_W - ANGLE_BITS)) - ANG_W'(1));
    localparam logic signed [CORDIC_W-1:0] CORDIC_START = CORDIC_W'(32'sh26DD3B6A);
    localparam logic signed [TRIG_W-1:0]   Q30_ONE      = 32'sh4000_0000;

    // Velocity lanes
    localparam int USEC_W = 20;
    localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;
    localparam int NUM_W      = DIFF_W + USEC_W;
    localparam int DIV_STEPS  = VEL_W - 1;
    localparam int LANE_STEPS = USEC_W + 1 + DIV_STEPS;
    localparam int LANE_CNT_W = $clog2(LANE_STEPS);

    // Rotation units
    localparam int ROT_CNT_W = $clog2(DIFF_W);
    localparam int ROT_ACC_W = 35;
    localparam int ROT_W     = ROT_ACC_W + 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_TRIG,
        ST_ROT,
        ST_COMMIT
    } t_poi_state;

    // Arctangent of 2^-i as a fraction of a full turn, 2^32 per turn
    function automatic logic [ANG_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        logic [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Saturate a widened sum to a 32-bit position
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ROT_W:0] v);
        logic [ROT_W-POS_W+1:0] upper;
        logic signed [POS_W-1:0] r;
        upper = v[ROT_W:POS_W-1];
        if ((&upper) || !(|upper)) begin
            r = v[POS_W-1:0];
        end else if (v[ROT_W]) begin
            r = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(POS_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/poi_ifs.sv
interface poi_pose_if import poi_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  pose_x;
    logic signed [POS_W-1:0]  pose_y;
    logic [HEAD_W-1:0]        pose_heading;
    logic [DT_W-1:0]          elapsed_time;

    modport source (output valid, pose_x, pose_y, pose_heading, elapsed_time,
                    input ready);
    modport sink   (input valid, pose_x, pose_y, pose_heading, elapsed_time,
                    output ready);
endinterface

interface poi_odom_if import poi_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  global_x;
    logic signed [POS_W-1:0]  global_y;
    logic signed [VEL_W-1:0]  velocity_x;
    logic signed [VEL_W-1:0]  velocity_y;
    logic signed [VEL_W-1:0]  velocity_heading;
    logic                     is_still;

    modport source (output valid, global_x, global_y, velocity_x, velocity_y,
                    velocity_heading, is_still, input ready);
    modport sink   (input valid, global_x, global_y, velocity_x, velocity_y,
                    velocity_heading, is_still, output ready);
endinterface

// File: hw/rtl/poi_cordic.sv
module poi_cordic import poi_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [ANG_W-1:0]         i_theta,
    output logic                     o_busy,
    output logic signed [TRIG_W-1:0] o_cos,
    output logic signed [TRIG_W-1:0] o_sin
);

    localparam logic [CORDIC_IDX_W-1:0]    ITER_LAST = CORDIC_IDX_W'(CORDIC_ITERS - 1);
    localparam logic signed [CORDIC_W-1:0] UNIT      = CORDIC_W'(Q30_ONE);

    logic                         r_busy;
    logic [CORDIC_IDX_W-1:0]      r_iter;
    logic signed [CORDIC_W-1:0]   r_x;
    logic signed [CORDIC_W-1:0]   r_y;
    logic signed [CORDIC_W-1:0]   r_z;
    logic                         r_flip;

    logic                         fold;
    logic [ANG_W-1:0]             z_start;
    logic signed [CORDIC_W-1:0]   xs;
    logic signed [CORDIC_W-1:0]   ys;
    logic signed [CORDIC_W-1:0]   step_ang;
    logic signed [CORDIC_W-1:0]   fx;
    logic signed [CORDIC_W-1:0]   fy;

    // Fold angles beyond a quarter turn by a half turn
    always_comb begin
        fold    = ($signed(i_theta) > Q30_ONE) || ($signed(i_theta) < -Q30_ONE);
        z_start = fold ? (i_theta ^ {1'b1, {(ANG_W-1){1'b0}}}) : i_theta;
    end

    always_comb begin
        xs       = r_x >>> r_iter;
        ys       = r_y >>> r_iter;
        step_ang = $signed({{(CORDIC_W-ANG_W){1'b0}},
                            atan_turn(ATAN_IDX_W'(r_iter))});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_iter <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_iter <= '0;
        end else if (r_busy) begin
            if (r_iter == ITER_LAST) begin
                r_busy <= 1'b0;
            end else begin
                r_iter <= r_iter + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_START;
            r_y    <= '0;
            r_z    <= $signed({{(CORDIC_W-ANG_W){z_start[ANG_W-1]}}, z_start});
            r_flip <= fold;
        end else if (r_busy) begin
            if (!r_z[CORDIC_W-1]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - step_ang;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + step_ang;
            end
        end
    end

    // Undo the fold, then clamp to the unit range
    always_comb begin
        fx = r_flip ? -r_x : r_x;
        fy = r_flip ? -r_y : r_y;
        if (fx > UNIT) begin
            o_cos = Q30_ONE;
        end else if (fx < -UNIT) begin
            o_cos = -Q30_ONE;
        end else begin
            o_cos = fx[TRIG_W-1:0];
        end
        if (fy > UNIT) begin
            o_sin = Q30_ONE;
        end else if (fy < -UNIT) begin
            o_sin = -Q30_ONE;
        end else begin
            o_sin = fy[TRIG_W-1:0];
        end
    end

    assign o_busy = r_busy;

endmodule

// File: hw/rtl/poi_rot.sv
module poi_rot import poi_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DIFF_W-1:0] i_a,
    input  logic signed [DIFF_W-1:0] i_b,
    input  logic signed [TRIG_W-1:0] i_p,
    input  logic signed [TRIG_W-1:0] i_q,
    output logic                     o_busy,
    output logic signed [ROT_W-1:0]  o_res
);

    // Serial multiply-add over the bits of a and b, LSB first:
    // res = floor((a*p + b*q + 2^29) / 2^30)

    localparam logic [ROT_CNT_W-1:0]        STEP_LAST = ROT_CNT_W'(DIFF_W - 1);
    localparam logic signed [ROT_ACC_W-1:0] ROUND     = ROT_ACC_W'(Q30_ONE >>> 1);

    logic                         r_busy;
    logic [ROT_CNT_W-1:0]         r_cnt;
    logic [DIFF_W-1:0]            r_a;
    logic [DIFF_W-1:0]            r_b;
    logic signed [TRIG_W-1:0]     r_p;
    logic signed [TRIG_W-1:0]     r_q;
    logic signed [ROT_ACC_W-1:0]  r_acc;
    logic [DIFF_W-1:0]            r_low;

    logic signed [ROT_ACC_W-1:0]  p_ext;
    logic signed [ROT_ACC_W-1:0]  q_ext;
    logic signed [ROT_ACC_W-1:0]  addend;
    logic signed [ROT_ACC_W-1:0]  sum;

    always_comb begin
        p_ext  = r_a[0] ? ROT_ACC_W'(r_p) : '0;
        q_ext  = r_b[0] ? ROT_ACC_W'(r_q) : '0;
        addend = p_ext + q_ext;
        // the sign bits weigh negative
        sum    = (r_cnt == STEP_LAST) ? (r_acc - addend) : (r_acc + addend);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == STEP_LAST) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_p   <= i_p;
            r_q   <= i_q;
            r_acc <= ROUND;
            r_low <= '0;
        end else if (r_busy) begin
            r_a   <= r_a >> 1;
            r_b   <= r_b >> 1;
            r_acc <= sum >>> 1;
            r_low <= {sum[0], r_low[DIFF_W-1:1]};
        end
    end

    assign o_busy = r_busy;
    assign o_res  = $signed({r_acc, r_low[DIFF_W-1 -: 3]});

endmodule

// File: hw/rtl/poi_vel.sv
module poi_vel import poi_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DIFF_W-1:0] i_diff,
    input  logic [DT_W-1:0]          i_dt,
    input  logic [THR_W-1:0]         i_thr,
    output logic                     o_busy,
    output logic signed [VEL_W-1:0]  o_vel,
    output logic                     o_still
);

    // Steps: multiply |diff| by 1e6 one constant bit a cycle, one range
    // check, then one quotient bit a cycle.

    localparam logic [LANE_CNT_W-1:0] MUL_END   = LANE_CNT_W'(USEC_W);
    localparam logic [LANE_CNT_W-1:0] STEP_LAST = LANE_CNT_W'(LANE_STEPS - 1);
    localparam int                    REM0_W    = NUM_W - DIV_STEPS;

    logic                     r_busy;
    logic [LANE_CNT_W-1:0]    r_step;
    logic                     r_neg;
    logic [DIFF_W-1:0]        r_mag;
    logic [USEC_W-1:0]        r_coef;
    logic [NUM_W-1:0]         r_num;
    logic [DT_W-1:0]          r_rem;
    logic                     r_sat;

    logic [NUM_W-1:0]         add_term;
    logic [REM0_W-1:0]        rem0;
    logic                     over;
    logic [DT_W:0]            trial;
    logic                     ge;
    logic [DT_W:0]            trial_sub;
    logic [DIV_STEPS-1:0]     quo;

    always_comb begin
        add_term  = r_coef[USEC_W-1] ? {{USEC_W{1'b0}}, r_mag} : '0;
        rem0      = r_num[NUM_W-1:DIV_STEPS];
        over      = rem0 >= {{(REM0_W-DT_W){1'b0}}, i_dt};
        trial     = {r_rem, r_num[DIV_STEPS-1]};
        ge        = trial >= {1'b0, i_dt};
        trial_sub = trial - {1'b0, i_dt};
        quo       = r_num[DIV_STEPS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            if ((r_step == MUL_END && over) || r_step == STEP_LAST) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_diff[DIFF_W-1];
            r_mag  <= i_diff[DIFF_W-1] ? DIFF_W'(-i_diff) : DIFF_W'(i_diff);
            r_coef <= USEC_PER_SEC;
            r_num  <= '0;
            r_sat  <= 1'b0;
        end else if (r_busy) begin
            if (r_step < MUL_END) begin
                r_num  <= (r_num << 1) + add_term;
                r_coef <= r_coef << 1;
            end else if (r_step == MUL_END) begin
                // quotient reaches 2^31: saturate, skip the division
                r_sat <= over;
                r_rem <= rem0[DT_W-1:0];
            end else begin
                r_rem                 <= ge ? trial_sub[DT_W-1:0] : trial[DT_W-1:0];
                r_num[DIV_STEPS-1:0]  <= {r_num[DIV_STEPS-2:0], ge};
            end
        end
    end

    always_comb begin
        if (r_sat) begin
            o_vel = r_neg ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
        end else if (r_neg) begin
            o_vel = -$signed({1'b0, quo});
        end else begin
            o_vel = $signed({1'b0, quo});
        end
        o_still = !r_sat && (quo <= {{(DIV_STEPS-THR_W){1'b0}}, i_thr});
    end

    assign o_busy = r_busy;

endmodule

// File: hw/rtl/planar_odometry_integrator.sv
// A pose beat is taken only in idle; the block then launches trig and the three velocity
// lanes, starts both rotation units once trig is done, and commits when all units are idle.
// The velocity lanes (multiply steps, one range check, divide steps) set the pace unless all
// three saturate at their range check and stop early; trig then rotation set it in that case.
// A result waits in the output register while the next pose is taken; commit stalls until
// the register is free. Reset (synchronous, active low) clears pose, accumulators, threshold.
module planar_odometry_integrator import poi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [THR_W-1:0]  i_cfg_wdata,
    poi_pose_if.sink          i_pose,
    poi_odom_if.source        o_odom
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_poi_state               r_state;
    t_poi_state               n_state;

    logic [THR_W-1:0]         r_thr;
    logic signed [POS_W-1:0]  r_last_x;
    logic signed [POS_W-1:0]  r_last_y;
    logic [HEAD_W-1:0]        r_last_h;
    logic signed [POS_W-1:0]  r_accum_x;
    logic signed [POS_W-1:0]  r_accum_y;

    // Operands of the item at work, held until commit
    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;
    logic [HEAD_W-1:0]        r_dh;
    logic [DT_W-1:0]          r_dt;
    logic [HEAD_W-1:0]        r_head;

    // Output register
    logic                     r_out_valid;
    logic signed [POS_W-1:0]  r_out_gx;
    logic signed [POS_W-1:0]  r_out_gy;
    logic signed [VEL_W-1:0]  r_out_vx;
    logic signed [VEL_W-1:0]  r_out_vy;
    logic signed [VEL_W-1:0]  r_out_vh;
    logic                     r_out_still;

    // ------------------------------------------------------------------
    // Control and datapath wires
    // ------------------------------------------------------------------
    logic                     accept;
    logic                     out_free;
    logic                     pose_ready;
    logic                     unit_start;
    logic                     rot_start;
    logic                     commit;

    logic signed [DIFF_W-1:0] dx_in;
    logic signed [DIFF_W-1:0] dy_in;
    logic [HEAD_W-1:0]        dh_in;
    logic [DT_W-1:0]          dt_in;
    logic [ANG_W-1:0]         theta;
    logic signed [DIFF_W-1:0] dh_ext;

    logic                     cordic_busy;
    logic signed [TRIG_W-1:0] trig_cos;
    logic signed [TRIG_W-1:0] trig_sin;
    logic signed [TRIG_W-1:0] trig_nsin;

    logic                     rot_busy_x;
    logic                     rot_busy_y;
    logic signed [ROT_W-1:0]  rot_x;
    logic signed [ROT_W-1:0]  rot_y;

    logic [2:0]               vel_busy;
    logic signed [VEL_W-1:0]  vel_x;
    logic signed [VEL_W-1:0]  vel_y;
    logic signed [VEL_W-1:0]  vel_h;
    logic [2:0]               vel_still;

    logic signed [ROT_W:0]    sum_x;
    logic signed [ROT_W:0]    sum_y;
    logic signed [POS_W-1:0]  new_x;
    logic signed [POS_W-1:0]  new_y;

    assign accept   = i_pose.valid && pose_ready;
    assign out_free = !r_out_valid || o_odom.ready;

    // Differences against the stored pose; heading wraps the short way round.
    // A zero elapsed time counts as one microsecond.
    always_comb begin
        dx_in = $signed({i_pose.pose_x[POS_W-1], i_pose.pose_x})
              - $signed({r_last_x[POS_W-1], r_last_x});
        dy_in = $signed({i_pose.pose_y[POS_W-1], i_pose.pose_y})
              - $signed({r_last_y[POS_W-1], r_last_y});
        dh_in = i_pose.pose_heading - r_last_h;
        dt_in = (i_pose.elapsed_time == '0) ? DT_W'(1) : i_pose.elapsed_time;
    end

    // Heading as a 32-bit binary angle, keep only the top ANGLE_BITS
    assign theta     = {r_head, {(ANG_W-HEAD_W){1'b0}}} & ANGLE_MASK;
    assign dh_ext    = $signed({{(DIFF_W-HEAD_W){r_dh[HEAD_W-1]}}, r_dh});
    assign trig_nsin = -trig_sin;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_pose.valid) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                n_state = ST_TRIG;
            end
            ST_TRIG: begin
                if (!cordic_busy) begin
                    n_state = ST_ROT;
                end
            end
            ST_ROT: begin
                if (!rot_busy_x && !rot_busy_y && !(|vel_busy)) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        pose_ready = 1'b0;
        unit_start = 1'b0;
        rot_start  = 1'b0;
        commit     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                pose_ready = 1'b1;
            end
            ST_START: begin
                // launch trig and the three velocity lanes together
                unit_start = 1'b1;
            end
            ST_TRIG: begin
                // rotation needs settled cosine and sine
                rot_start = !cordic_busy;
            end
            ST_ROT: begin
            end
            ST_COMMIT: begin
                // hold until the output register frees up
                commit = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Configuration and pose state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= '0;
            r_last_x  <= '0;
            r_last_y  <= '0;
            r_last_h  <= '0;
            r_accum_x <= '0;
            r_accum_y <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (accept) begin
                r_last_x <= i_pose.pose_x;
                r_last_y <= i_pose.pose_y;
                r_last_h <= i_pose.pose_heading;
            end
            if (commit) begin
                r_accum_x <= new_x;
                r_accum_y <= new_y;
            end
        end
    end

    // Capture operands on the accepted beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dx   <= dx_in;
            r_dy   <= dy_in;
            r_dh   <= dh_in;
            r_dt   <= dt_in;
            r_head <= i_pose.pose_heading;
        end
    end

    // ------------------------------------------------------------------
    // Units
    // ------------------------------------------------------------------
    poi_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (unit_start),
        .i_theta (theta),
        .o_busy  (cordic_busy),
        .o_cos   (trig_cos),
        .o_sin   (trig_sin)
    );

    // x: dx*cos - dy*sin
    poi_rot u_rot_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rot_start),
        .i_a     (r_dx),
        .i_b     (r_dy),
        .i_p     (trig_cos),
        .i_q     (trig_nsin),
        .o_busy  (rot_busy_x),
        .o_res   (rot_x)
    );

    // y: dx*sin + dy*cos
    poi_rot u_rot_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rot_start),
        .i_a     (r_dx),
        .i_b     (r_dy),
        .i_p     (trig_sin),
        .i_q     (trig_cos),
        .o_busy  (rot_busy_y),
        .o_res   (rot_y)
    );

    poi_vel u_vel_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (unit_start),
        .i_diff  (r_dx),
        .i_dt    (r_dt),
        .i_thr   (r_thr),
        .o_busy  (vel_busy[0]),
        .o_vel   (vel_x),
        .o_still (vel_still[0])
    );

    poi_vel u_vel_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (unit_start),
        .i_diff  (r_dy),
        .i_dt    (r_dt),
        .i_thr   (r_thr),
        .o_busy  (vel_busy[1]),
        .o_vel   (vel_y),
        .o_still (vel_still[1])
    );

    poi_vel u_vel_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (unit_start),
        .i_diff  (dh_ext),
        .i_dt    (r_dt),
        .i_thr   (r_thr),
        .o_busy  (vel_busy[2]),
        .o_vel   (vel_h),
        .o_still (vel_still[2])
    );

    // ------------------------------------------------------------------
    // Accumulate with saturation
    // ------------------------------------------------------------------
    always_comb begin
        sum_x = $signed({{(ROT_W+1-POS_W){r_accum_x[POS_W-1]}}, r_accum_x})
              + $signed({rot_x[ROT_W-1], rot_x});
        sum_y = $signed({{(ROT_W+1-POS_W){r_accum_y[POS_W-1]}}, r_accum_y})
              + $signed({rot_y[ROT_W-1], rot_y});
        new_x = sat_pos(sum_x);
        new_y = sat_pos(sum_y);
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (o_odom.ready) begin
            // drop the beat once taken
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_gx    <= new_x;
            r_out_gy    <= new_y;
            r_out_vx    <= vel_x;
            r_out_vy    <= vel_y;
            r_out_vh    <= vel_h;
            r_out_still <= &vel_still;
        end
    end

    assign i_pose.ready            = pose_ready;
    assign o_odom.valid            = r_out_valid;
    assign o_odom.global_x         = r_out_gx;
    assign o_odom.global_y         = r_out_gy;
    assign o_odom.velocity_x       = r_out_vx;
    assign o_odom.velocity_y       = r_out_vy;
    assign o_odom.velocity_heading = r_out_vh;
    assign o_odom.is_still         = r_out_still;

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_START))
        else $error("accepted beat did not launch the units");

    a_ready_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pose_ready |-> (!cordic_busy && !rot_busy_x && !rot_busy_y && !(|vel_busy)))
        else $error("pose taken while a unit is still busy");

    a_rot_after_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROT) |-> !cordic_busy)
        else $error("rotation running on unsettled trig values");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> o_odom.valid)
        else $error("committed result not presented");

    a_still_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_odom.valid && o_odom.is_still) |->
            (o_odom.velocity_x <= 65535 && o_odom.velocity_x >= -65535))
        else $error("still flag set with a large x velocity");
`endif

endmodule

// File: bench/poi_odom_check.sv
`timescale 1ns / 1ps

module poi_odom_check import poi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [THR_W-1:0] i_cfg_wdata,
    poi_pose_if              i_pose,
    poi_odom_if              i_odom,
    output int unsigned      o_fail_count,
    output int unsigned      o_pending
);

    localparam longint MICROS_PER_S = 64'sd1000000;
    localparam longint UNIT_Q30     = 64'sd1073741824;
    localparam longint HALF_Q30     = 64'sd536870912;
    localparam longint GAIN_START   = 64'sh26DD3B6A;
    localparam longint S32_MAX      = 64'sd2147483647;
    localparam longint S32_MIN      = -64'sd2147483648;
    localparam int     MAX_PRINTS   = 40;

    // Arctangent of 2^-i in turns, 2^32 per turn
    localparam logic [31:0] ATAN_TURNS [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct {
        logic signed [POS_W-1:0] global_x;
        logic signed [POS_W-1:0] global_y;
        logic signed [VEL_W-1:0] velocity_x;
        logic signed [VEL_W-1:0] velocity_y;
        logic signed [VEL_W-1:0] velocity_heading;
        logic                    is_still;
    } t_odom_beat;

    logic signed [POS_W-1:0] prev_x;
    logic signed [POS_W-1:0] prev_y;
    logic [HEAD_W-1:0]       prev_heading;
    logic signed [POS_W-1:0] track_x;
    logic signed [POS_W-1:0] track_y;
    logic [THR_W-1:0]        still_thr;
    t_odom_beat              odom_expected_q[$];
    int unsigned             beat_idx  = 0;
    int unsigned             n_fail    = 0;
    int unsigned             n_waiting = 0;

    assign o_fail_count = n_fail;
    assign o_pending    = n_waiting;

    function automatic logic signed [31:0] sat_to_32(input longint v);
        if (v > S32_MAX) return 32'sh7FFFFFFF;
        if (v < S32_MIN) return 32'sh80000000;
        return 32'(v);
    endfunction

    function automatic longint magnitude(input logic signed [31:0] v);
        longint w;
        w = longint'(v);
        return (w < 0) ? -w : w;
    endfunction

    // Q2.30 cosine and sine of the heading, folded CORDIC rotation
    function automatic void heading_sin_cos(input logic [HEAD_W-1:0] heading,
                                            output longint cos_q30,
                                            output longint sin_q30);
        logic [ANG_W-1:0] theta;
        logic             fold;
        longint           cx, cy, z, xs, ys;
        theta = (ANG_W'(heading) << (ANG_W - HEAD_W)) & ANGLE_MASK;
        z     = longint'(signed'(theta));
        fold  = (z > UNIT_Q30) || (z < -UNIT_Q30);
        if (fold) begin
            z = longint'(signed'(theta + 32'h8000_0000));
        end
        cx = GAIN_START;
        cy = 0;
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (z >= 0) begin
                cx = cx - ys;
                cy = cy + xs;
                z  = z - longint'({32'h0, ATAN_TURNS[i]});
            end else begin
                cx = cx + ys;
                cy = cy - xs;
                z  = z + longint'({32'h0, ATAN_TURNS[i]});
            end
        end
        if (fold) begin
            cx = -cx;
            cy = -cy;
        end
        cos_q30 = (cx > UNIT_Q30) ? UNIT_Q30 : (cx < -UNIT_Q30) ? -UNIT_Q30 : cx;
        sin_q30 = (cy > UNIT_Q30) ? UNIT_Q30 : (cy < -UNIT_Q30) ? -UNIT_Q30 : cy;
    endfunction

    // Advance the dead-reckoning state by one pose sample
    function automatic t_odom_beat predict_odometry(input logic signed [POS_W-1:0] px,
                                                    input logic signed [POS_W-1:0] py,
                                                    input logic [HEAD_W-1:0]       ph,
                                                    input logic [DT_W-1:0]         et);
        t_odom_beat        r;
        longint            dt, dx, dy, dh, c, s, rx, ry, thr;
        logic [HEAD_W-1:0] hdiff;
        dt    = (et == '0) ? 64'sd1 : longint'({44'h0, et});
        dx    = longint'(px) - longint'(prev_x);
        dy    = longint'(py) - longint'(prev_y);
        hdiff = ph - prev_heading;
        dh    = longint'(signed'(hdiff));

        r.velocity_x       = sat_to_32(dx * MICROS_PER_S / dt);
        r.velocity_y       = sat_to_32(dy * MICROS_PER_S / dt);
        r.velocity_heading = sat_to_32(dh * MICROS_PER_S / dt);

        heading_sin_cos(ph, c, s);
        rx      = (dx * c - dy * s + HALF_Q30) >>> 30;
        ry      = (dx * s + dy * c + HALF_Q30) >>> 30;
        track_x = sat_to_32(longint'(track_x) + rx);
        track_y = sat_to_32(longint'(track_y) + ry);
        r.global_x = track_x;
        r.global_y = track_y;

        prev_x       = px;
        prev_y       = py;
        prev_heading = ph;

        thr        = longint'({48'h0, still_thr});
        r.is_still = (magnitude(r.velocity_x) <= thr) && (magnitude(r.velocity_y) <= thr) &&
                     (magnitude(r.velocity_heading) <= thr);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (n_fail < MAX_PRINTS) begin
            $display("[%0t] odom beat %0d: %s", $realtime, beat_idx, msg);
        end
        n_fail++;
    endtask

    always @(posedge i_clk) begin
        t_odom_beat want;
        if (!i_rst_n) begin
            prev_x       = '0;
            prev_y       = '0;
            prev_heading = '0;
            track_x      = '0;
            track_y      = '0;
            still_thr    = '0;
            odom_expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                still_thr = i_cfg_wdata;
            end
            // Retire the result beat before booking a new pose beat
            if (i_odom.valid && i_odom.ready) begin
                if (odom_expected_q.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = odom_expected_q.pop_front();
                    if (i_odom.global_x !== want.global_x)
                        report_mismatch($sformatf("global_x got %0d expected %0d",
                                                  i_odom.global_x, want.global_x));
                    if (i_odom.global_y !== want.global_y)
                        report_mismatch($sformatf("global_y got %0d expected %0d",
                                                  i_odom.global_y, want.global_y));
                    if (i_odom.velocity_x !== want.velocity_x)
                        report_mismatch($sformatf("velocity_x got %0d expected %0d",
                                                  i_odom.velocity_x, want.velocity_x));
                    if (i_odom.velocity_y !== want.velocity_y)
                        report_mismatch($sformatf("velocity_y got %0d expected %0d",
                                                  i_odom.velocity_y, want.velocity_y));
                    if (i_odom.velocity_heading !== want.velocity_heading)
                        report_mismatch($sformatf("velocity_heading got %0d expected %0d",
                                                  i_odom.velocity_heading,
                                                  want.velocity_heading));
                    if (i_odom.is_still !== want.is_still)
                        report_mismatch($sformatf("is_still got %b expected %b",
                                                  i_odom.is_still, want.is_still));
                end
                beat_idx++;
            end
            if (i_pose.valid && i_pose.ready) begin
                odom_expected_q.push_back(predict_odometry(i_pose.pose_x, i_pose.pose_y,
                                                           i_pose.pose_heading,
                                                           i_pose.elapsed_time));
            end
        end
        n_waiting <= odom_expected_q.size();
    end

endmodule

// File: bench/planar_odometry_integrator_tb.sv
`timescale 1ns / 1ps

module planar_odometry_integrator_tb;
    import poi_pkg::*;

    localparam int     RESET_CYCLES = 6;
    localparam int     PHASE_POSES  = 500;
    // Wait a little longer after the drain than the block needs per result
    localparam int     SETTLE_CYCLES = 80;
    localparam longint CYCLE_LIMIT   = 1000000;

    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;
    localparam logic signed [POS_W-1:0] ONE_M   = 32'sh0001_0000;
    localparam logic [DT_W-1:0]         DT_MAX  = '1;
    localparam logic [DT_W-1:0]         DT_SEC  = 20'd1000000;

    // Headings on and around the quarter-turn fold and the wrap
    localparam logic [HEAD_W-1:0] FOLD_HEADINGS [11] = '{
        16'h0000, 16'h3FFF, 16'h4000, 16'h4001, 16'h7FFF, 16'h8000,
        16'h8001, 16'hBFFF, 16'hC000, 16'hC001, 16'hFFFF
    };

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [THR_W-1:0] i_cfg_wdata = '0;

    poi_pose_if pose_bus ();
    poi_odom_if odom_bus ();

    int unsigned fail_count;
    int unsigned pending;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    longint      cycle_count   = 0;

    // Last pose handed to the block; the smooth-motion stimulus walks from it
    logic signed [POS_W-1:0] cur_x;
    logic signed [POS_W-1:0] cur_y;
    logic [HEAD_W-1:0]       cur_h;

    planar_odometry_integrator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pose      (pose_bus),
        .o_odom      (odom_bus)
    );

    poi_odom_check u_odom_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_pose       (pose_bus),
        .i_odom       (odom_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 4 ns period
    always #2 i_clk = ~i_clk;

    // Result side: drop ready at random per the current idle mix
    initial begin
        odom_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            odom_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: count cycles and end the run if it never drains
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Present one pose beat and hold it until the block takes it. Valid stays
    // high after the beat so back-to-back beats never toggle it in one step.
    task automatic send_pose(input logic signed [POS_W-1:0] x,
                             input logic signed [POS_W-1:0] y,
                             input logic [HEAD_W-1:0]       h,
                             input logic [DT_W-1:0]         et);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            pose_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        pose_bus.valid        <= 1'b1;
        pose_bus.pose_x       <= x;
        pose_bus.pose_y       <= y;
        pose_bus.pose_heading <= h;
        pose_bus.elapsed_time <= et;
        @(posedge i_clk);
        while (!pose_bus.ready) @(posedge i_clk);
        cur_x = x;
        cur_y = y;
        cur_h = h;
    endtask

    // Hold off the sender until every booked result has come back
    task automatic drain_results();
        pose_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Every pose yields a result, so an empty scoreboard means the block is idle
    task automatic write_still_threshold(input logic [THR_W-1:0] thr);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= thr;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly smooth trajectories with random content; the rest jumps, stands
    // still, hits the fold headings or the elapsed-time corners, or is noise.
    task automatic send_random_pose();
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [HEAD_W-1:0]       h;
        logic [DT_W-1:0]         et;
        int unsigned             kind;
        kind = $urandom_range(0, 19);
        x  = cur_x + ($urandom_range(0, 2097152) - 1048576);
        y  = cur_y + ($urandom_range(0, 2097152) - 1048576);
        h  = cur_h + HEAD_W'($urandom_range(0, 4000)) - 16'd2000;
        et = DT_W'($urandom_range(200, 5000));
        case (kind)
            12, 13: begin
                // near standstill: tiny moves over long intervals
                x  = cur_x + ($urandom_range(0, 4) - 2);
                y  = cur_y + ($urandom_range(0, 4) - 2);
                h  = cur_h + HEAD_W'($urandom_range(0, 2)) - 16'd1;
                et = DT_W'($urandom_range(10000, 1000000));
            end
            14, 15: begin
                x  = $urandom;
                y  = $urandom;
                h  = HEAD_W'($urandom);
                et = DT_W'($urandom);
            end
            16: begin
                x  = ($urandom_range(0, 1) != 0) ? POS_MAX : POS_MIN;
                y  = ($urandom_range(0, 2) == 0) ? '0 :
                     ($urandom_range(0, 1) != 0) ? POS_MAX : POS_MIN;
                et = ($urandom_range(0, 1) != 0) ? DT_W'(0) : DT_W'(1);
            end
            17: begin
                h = FOLD_HEADINGS[$urandom_range(0, 10)];
            end
            18: begin
                case ($urandom_range(0, 4))
                    0:       et = '0;
                    1:       et = DT_W'(1);
                    2:       et = DT_SEC;
                    3:       et = DT_MAX;
                    default: et = DT_W'($urandom);
                endcase
            end
            19: begin
                h = HEAD_W'($urandom);
            end
            default: ;
        endcase
        send_pose(x, y, h, et);
    endtask

    task automatic run_random_phase(input int unsigned s_idle, input int unsigned r_idle,
                                    input int unsigned count);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int unsigned k = 0; k < count; k++) begin
            send_random_pose();
            // pause the sender mid-phase until the pipeline is empty
            if (k == count / 2) drain_results();
        end
    endtask

    initial begin
        pose_bus.valid        = 1'b0;
        pose_bus.pose_x       = '0;
        pose_bus.pose_y       = '0;
        pose_bus.pose_heading = '0;
        pose_bus.elapsed_time = '0;
        cur_x = '0;
        cur_y = '0;
        cur_h = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 11;
        recv_idle_pct = 56;

        // Directed part with the reset threshold of zero.
        // First sample is taken against the zero pose; zero dt counts as one.
        send_pose('0, '0, 16'h0000, '0);
        send_pose(ONE_M, '0, 16'h0000, 20'd1000);
        // Full-scale swings with dt of one: saturate every velocity
        send_pose(POS_MAX, POS_MIN, 16'h4000, DT_W'(1));
        send_pose(POS_MIN, POS_MAX, 16'hC000, '0);
        send_pose('0, ONE_M, 16'h8000, 20'd500);
        // Heading steps across the half-turn wrap
        send_pose(ONE_M, ONE_M, 16'h7FFF, 20'd2000);
        send_pose(ONE_M, ONE_M, 16'h0001, 20'd2000);
        send_pose(-ONE_M, ONE_M, 16'hFFFF, DT_MAX);
        send_pose(-ONE_M, -ONE_M, 16'h8001, DT_SEC);
        send_pose(-ONE_M, -ONE_M, 16'h8001, DT_SEC);

        // Widest threshold: small motion now reads as standing still
        write_still_threshold(16'hFFFF);
        send_pose(-ONE_M, -ONE_M, 16'h8001, DT_SEC);
        send_pose(-ONE_M + 1, -ONE_M - 1, 16'h8000, 20'd1000);
        send_pose(ONE_M, ONE_M, 16'h3FFF, 20'd100);
        send_pose(ONE_M, ONE_M, 16'h4001, 20'd100);
        send_pose(2 * ONE_M, ONE_M, 16'hBFFF, 20'd100);
        send_pose(2 * ONE_M, 3 * ONE_M, 16'hC001, 20'd100);
        // Drive both accumulators into their limits and back out
        send_pose(POS_MAX, POS_MAX, 16'h0000, DT_SEC);
        send_pose(POS_MIN, POS_MIN, 16'h0000, DT_SEC);
        send_pose(POS_MAX, POS_MAX, 16'h0000, DT_SEC);
        send_pose(POS_MAX, POS_MAX, 16'h2000, DT_SEC);
        send_pose(POS_MIN, POS_MIN, 16'h8000, DT_SEC);
        send_pose(POS_MAX, POS_MAX, 16'h8000, DT_SEC);

        // Random phases: sender-light/receiver-heavy, swapped, then full rate
        write_still_threshold('0);
        run_random_phase(11, 56, PHASE_POSES);
        write_still_threshold(THR_W'($urandom));
        run_random_phase(56, 11, PHASE_POSES);
        write_still_threshold(16'd3000);
        run_random_phase(0, 0, PHASE_POSES);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
